@@ rtl/hsvgo_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvgo_pkg
// Shared constants, types and reciprocal tables for the HSV go detector.
// ----------------------------------------------------------------------------
package hsvgo_pkg;

    localparam int WINDOW_LEN       = 10;
    localparam int MAX_FRAME_PIXELS = 2097152;
    localparam int TALLY_W          = 22;
    localparam int CNT_W            = 25;
    localparam int FILL_W           = 4;
    localparam int SUM_W            = 7;
    localparam int HSV_SHIFT        = 12;
    localparam int HUE_SCALE        = (180 << HSV_SHIFT) / 6;

    localparam logic [1:0] VOTE_NONE = 2'd0;
    localparam logic [1:0] VOTE_GO   = 2'd1;
    localparam logic [1:0] VOTE_STOP = 2'd2;

    localparam logic [1:0] REG_GREEN_LOW  = 2'd0;
    localparam logic [1:0] REG_GREEN_HIGH = 2'd1;
    localparam logic [1:0] REG_RED_LOW    = 2'd2;
    localparam logic [1:0] REG_RED_HIGH   = 2'd3;

    localparam logic [23:0] GREEN_LOW_RST  = 24'h280FAA;
    localparam logic [23:0] GREEN_HIGH_RST = 24'h4646FF;
    localparam logic [23:0] RED_LOW_RST    = 24'h000046;
    localparam logic [23:0] RED_HIGH_RST   = 24'h19A0FF;

    typedef struct packed {
        logic pixel;
        logic frame_end;
        logic request;
        logic request_value;
    } hsvgo_cmd_t;

    typedef struct packed {
        logic busy;
    } hsvgo_status_t;

    typedef logic [255:0][19:0] sat_tab_t;
    typedef logic [255:0][17:0] hue_tab_t;

    // restoring division, evaluated at elaboration only
    function automatic int const_div(input int num, input int den);
        int q, r;
        begin
            q = 0;
            r = 0;
            for (int k = 30; k >= 0; k--)
            begin
                r = (r << 1) | ((num >> k) & 1);
                if (r >= den)
                begin
                    r = r - den;
                    q = q | (1 << k);
                end
            end
            return q;
        end
    endfunction

    // round(255*4096/i), zero for i = 0
    function automatic sat_tab_t build_sat_tab();
        sat_tab_t t;
        begin
            t = '0;
            for (int i = 1; i < 256; i++)
                t[i] = 20'(const_div(2 * (255 << HSV_SHIFT) + i, 2 * i));
            return t;
        end
    endfunction

    // round(30*4096/i), zero for i = 0
    function automatic hue_tab_t build_hue_tab();
        hue_tab_t t;
        begin
            t = '0;
            for (int i = 1; i < 256; i++)
                t[i] = 18'(const_div(2 * HUE_SCALE + i, 2 * i));
            return t;
        end
    endfunction

    localparam sat_tab_t SAT_RECIP_TAB = build_sat_tab();
    localparam hue_tab_t HUE_RECIP_TAB = build_hue_tab();

endpackage

@@ rtl/hsv_color_vote_go_detector.sv @@
// ----------------------------------------------------------------------------
// hsv_color_vote_go_detector
// Pixels and crossing requests are taken one per cycle; a frame-end pixel runs
// a 4-stage pipeline and the block takes no transaction until its result leaves.
// The result is presented once stage 4 resolves the frame and the controller holds it; the
// next transaction is accepted when the result leaves, which out_stall can delay.
// Reset: asynchronous, active low; boxes return to defaults, counts and window clear.
// ----------------------------------------------------------------------------
module hsv_color_vote_go_detector
    import hsvgo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic                frame_end,
    input  logic                crossing_request,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          frame_vote,
    output logic [TALLY_W-1:0]  green_pixels,
    output logic [TALLY_W-1:0]  red_pixels,
    output logic [FILL_W-1:0]   window_fill,
    output logic                red_seen_out,
    output logic                go_event,
    output logic                go_flag
);

    logic [23:0] glo_reg, ghi_reg, rlo_reg, rhi_reg;
    hsvgo_cmd_t    cmd;
    hsvgo_status_t status;
    logic          res_done;
    logic          wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glo_reg <= GREEN_LOW_RST;
            ghi_reg <= GREEN_HIGH_RST;
            rlo_reg <= RED_LOW_RST;
            rhi_reg <= RED_HIGH_RST;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_GREEN_LOW:  glo_reg <= pwdata[23:0];
                REG_GREEN_HIGH: ghi_reg <= pwdata[23:0];
                REG_RED_LOW:    rlo_reg <= pwdata[23:0];
                REG_RED_HIGH:   rhi_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GREEN_LOW:  prdata = {8'd0, glo_reg};
            REG_GREEN_HIGH: prdata = {8'd0, ghi_reg};
            REG_RED_LOW:    prdata = {8'd0, rlo_reg};
            REG_RED_HIGH:   prdata = {8'd0, rhi_reg};
            default:        prdata = '0;
        endcase
    end

    hsvgo_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .frame_end        (frame_end),
        .crossing_request (crossing_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .res_done         (res_done),
        .status           (status),
        .cmd              (cmd)
    );

    hsvgo_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .green_lo     (glo_reg),
        .green_hi     (ghi_reg),
        .red_lo       (rlo_reg),
        .red_hi       (rhi_reg),
        .status       (status),
        .res_done     (res_done),
        .frame_vote   (frame_vote),
        .green_pixels (green_pixels),
        .red_pixels   (red_pixels),
        .window_fill  (window_fill),
        .red_seen_out (red_seen_out),
        .go_event     (go_event),
        .go_flag      (go_flag)
    );

endmodule

@@ rtl/hsvgo_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsvgo_ctrl
// Handshake controller: accepts one transaction at a time and holds results.
// ----------------------------------------------------------------------------
module hsvgo_ctrl
    import hsvgo_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          kind,
    input  logic          frame_end,
    input  logic          crossing_request,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic          res_done,
    input  hsvgo_status_t status,
    output hsvgo_cmd_t    cmd
);

    localparam logic [0:0] ST_RUN  = 1'b0;
    localparam logic [0:0] ST_HOLD = 1'b1;

    logic [0:0] state_reg, state_next;
    logic       accept;

    assign in_stall  = (state_reg == ST_HOLD) || status.busy;
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_HOLD);

    assign cmd.pixel         = accept && !kind;
    assign cmd.frame_end     = accept && !kind && frame_end;
    assign cmd.request       = accept && kind;
    assign cmd.request_value = crossing_request;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (res_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_stall)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

    a_no_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cmd.pixel && !cmd.request)
        else $error("accept while holding result");
    a_done_goes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |=> out_valid)
        else $error("result not presented");
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !cmd.pixel)
        else $error("accept while busy");

endmodule

@@ rtl/hsvgo_datapath.sv @@
// ----------------------------------------------------------------------------
// hsvgo_datapath
// Pipelined BGR to HSV conversion, box tallies and vote window logic.
// ----------------------------------------------------------------------------
module hsvgo_datapath
    import hsvgo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hsvgo_cmd_t          cmd,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic [23:0]         green_lo,
    input  logic [23:0]         green_hi,
    input  logic [23:0]         red_lo,
    input  logic [23:0]         red_hi,
    output hsvgo_status_t       status,
    output logic                res_done,
    output logic [1:0]          frame_vote,
    output logic [TALLY_W-1:0]  green_pixels,
    output logic [TALLY_W-1:0]  red_pixels,
    output logic [FILL_W-1:0]   window_fill,
    output logic                red_seen_out,
    output logic                go_event,
    output logic                go_flag
);

    // stage 1: max, min, hue numerator, reciprocals
    logic        s1_vld_reg, s1_end_reg;
    logic [7:0]  s1_v_reg, s1_diff_reg;
    logic signed [11:0] s1_hnum_reg;
    logic [19:0] s1_srec_reg;
    logic [17:0] s1_hrec_reg;
    // stage 2: products
    logic        s2_vld_reg, s2_end_reg;
    logic [7:0]  s2_v_reg;
    logic [27:0] s2_sprod_reg;
    logic signed [28:0] s2_hprod_reg;
    // stage 3: hsv
    logic        s3_vld_reg, s3_end_reg;
    logic [23:0] s3_hsv_reg;
    // stage 4: resolve frame
    logic        s4_vld_reg;

    // pixel presence in each stage, independent of frame end
    logic p1_reg, p2_reg, s3_pix_reg;

    logic [7:0] mx, mn, df;
    logic signed [11:0] hn;
    logic [16:0] s_sum;
    logic signed [29:0] h_sum;
    logic signed [17:0] h_rnd;
    logic [7:0] h_fin, s_fin;

    logic [CNT_W-1:0] gt_reg, rt_reg, gt_next, rt_next;
    logic [WINDOW_LEN-1:0] win_reg;
    logic [FILL_W-1:0] fill_reg;
    logic red_seen_reg, pend_reg, go_reg;
    logic [1:0] vote_reg;
    logic [TALLY_W-1:0] gp_reg, rp_reg;
    logic ev_reg;
    logic in_g, in_r;

    assign status.busy = s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg;

    always_comb
    begin
        mx = blue;
        mn = blue;
        if (green > mx) mx = green;
        if (red > mx)   mx = red;
        if (green < mn) mn = green;
        if (red < mn)   mn = red;
        df = mx - mn;
        if (mx == red)
            hn = $signed({4'b0, green}) - $signed({4'b0, blue});
        else if (mx == green)
            hn = $signed({4'b0, blue}) - $signed({4'b0, red})
                + $signed({3'b0, df, 1'b0});
        else
            hn = $signed({4'b0, red}) - $signed({4'b0, green})
                + $signed({2'b0, df, 2'b0});
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg     <= mx;
        s1_diff_reg  <= df;
        s1_hnum_reg  <= hn;
        s1_srec_reg  <= SAT_RECIP_TAB[mx];
        s1_hrec_reg  <= HUE_RECIP_TAB[df];
        s1_end_reg   <= cmd.frame_end;
        s2_v_reg     <= s1_v_reg;
        s2_end_reg   <= s1_end_reg;
        s2_sprod_reg <= 28'(s1_diff_reg) * 28'(s1_srec_reg);
        s2_hprod_reg <= 29'(s1_hnum_reg) * 29'(signed'({1'b0, s1_hrec_reg}));
        s3_end_reg   <= s2_end_reg;
        s3_hsv_reg   <= {h_fin, s_fin, s2_v_reg};
    end

    always_comb
    begin
        s_sum = 17'((29'(s2_sprod_reg) + 29'd2048) >> HSV_SHIFT);
        s_fin = s_sum[7:0];
        h_sum = 30'(s2_hprod_reg) + 30'sd2048;
        h_rnd = 18'(h_sum >>> HSV_SHIFT);
        if (h_rnd < 0)
            h_fin = 8'(h_rnd + 18'sd180);
        else
            h_fin = h_rnd[7:0];
    end

    always_comb
    begin
        in_g = s3_hsv_reg[23:16] >= green_lo[23:16] && s3_hsv_reg[23:16] <= green_hi[23:16]
            && s3_hsv_reg[15:8] >= green_lo[15:8] && s3_hsv_reg[15:8] <= green_hi[15:8]
            && s3_hsv_reg[7:0] >= green_lo[7:0] && s3_hsv_reg[7:0] <= green_hi[7:0];
        in_r = s3_hsv_reg[23:16] >= red_lo[23:16] && s3_hsv_reg[23:16] <= red_hi[23:16]
            && s3_hsv_reg[15:8] >= red_lo[15:8] && s3_hsv_reg[15:8] <= red_hi[15:8]
            && s3_hsv_reg[7:0] >= red_lo[7:0] && s3_hsv_reg[7:0] <= red_hi[7:0];
        gt_next = gt_reg;
        rt_next = rt_reg;
        if (in_g && gt_reg < CNT_W'(MAX_FRAME_PIXELS))
            gt_next = gt_reg + 1'b1;
        if (in_r && rt_reg < CNT_W'(MAX_FRAME_PIXELS))
            rt_next = rt_reg + 1'b1;
    end

    // vote window, resolved the cycle after a frame's last tally
    logic [1:0] v;
    logic [WINDOW_LEN-1:0] w1;
    logic [FILL_W-1:0] f1;
    logic [SUM_W-1:0] wsum;
    logic [WINDOW_LEN-1:0] win_next;
    logic [FILL_W-1:0] fill_next;
    logic rs_next, pend_next, go_next, ev_next;

    always_comb
    begin
        v = VOTE_NONE;
        if (gt_reg > rt_reg)
            v = VOTE_GO;
        else if (rt_reg > gt_reg)
            v = VOTE_STOP;
        w1 = win_reg;
        f1 = fill_reg;
        if (v != VOTE_NONE && fill_reg < FILL_W'(WINDOW_LEN))
        begin
            w1[fill_reg] = (v == VOTE_GO);
            f1 = fill_reg + 1'b1;
        end
        wsum = SUM_W'($countones(w1));
        win_next  = w1;
        fill_next = f1;
        rs_next   = red_seen_reg;
        pend_next = pend_reg;
        go_next   = go_reg;
        ev_next   = 1'b0;
        if (f1 >= FILL_W'(WINDOW_LEN))
        begin
            win_next = w1 >> 1;
            if ({wsum, 1'b0} >= (SUM_W + 1)'(f1))
            begin
                if (red_seen_reg && pend_reg)
                begin
                    go_next   = 1'b1;
                    ev_next   = 1'b1;
                    rs_next   = 1'b0;
                    pend_next = 1'b0;
                    win_next  = '0;
                    fill_next = '0;
                end
                else
                    fill_next = f1 - 1'b1;
            end
            else
            begin
                rs_next   = 1'b1;
                fill_next = f1 - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            gt_reg       <= '0;
            rt_reg       <= '0;
            win_reg      <= '0;
            fill_reg     <= '0;
            red_seen_reg <= 1'b0;
            pend_reg     <= 1'b0;
            go_reg       <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.pixel && cmd.frame_end;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg && s3_end_reg;
            if (cmd.request)
                pend_reg <= cmd.request_value;
            if (s3_pix_reg)
            begin
                gt_reg <= gt_next;
                rt_reg <= rt_next;
            end
            if (s4_vld_reg)
            begin
                win_reg      <= win_next;
                fill_reg     <= fill_next;
                red_seen_reg <= rs_next;
                pend_reg     <= pend_next;
                go_reg       <= go_next;
                gt_reg       <= '0;
                rt_reg       <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg     <= 1'b0;
            p2_reg     <= 1'b0;
            s3_pix_reg <= 1'b0;
        end
        else
        begin
            p1_reg     <= cmd.pixel;
            p2_reg     <= p1_reg;
            s3_pix_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_vld_reg)
        begin
            vote_reg <= v;
            gp_reg   <= gt_reg[TALLY_W-1:0];
            rp_reg   <= rt_reg[TALLY_W-1:0];
            ev_reg   <= ev_next;
        end
    end

    assign res_done     = s4_vld_reg;
    assign frame_vote   = vote_reg;
    assign green_pixels = gp_reg;
    assign red_pixels   = rp_reg;
    assign window_fill  = fill_reg;
    assign red_seen_out = red_seen_reg;
    assign go_event     = ev_reg;
    assign go_flag      = go_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(WINDOW_LEN))
        else $error("window fill out of range");
    a_go_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |=> go_reg)
        else $error("go flag cleared");
    a_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg && ev_next |=> fill_reg == '0 && !red_seen_reg)
        else $error("go did not clear window");

endmodule

@@ dv/hsv_color_vote_go_detector_chk.sv @@
// ----------------------------------------------------------------------------
// hsv_color_vote_go_detector_chk
// Watches the input, result and register channels of the go detector, keeps
// its own copy of the boxes, tallies and vote window, and compares every
// result transaction field by field with the predicted frame summary.
// ----------------------------------------------------------------------------
module hsv_color_vote_go_detector_chk
    import hsvgo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic                frame_end,
    input  logic                crossing_request,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          frame_vote,
    input  logic [TALLY_W-1:0]  green_pixels,
    input  logic [TALLY_W-1:0]  red_pixels,
    input  logic [FILL_W-1:0]   window_fill,
    input  logic                red_seen_out,
    input  logic                go_event,
    input  logic                go_flag,
    output int                  fail_count,
    output int                  pending_frames
);

    typedef struct packed {
        logic [1:0]         vote;
        logic [TALLY_W-1:0] gcnt;
        logic [TALLY_W-1:0] rcnt;
        logic [FILL_W-1:0]  fill;
        logic               seen;
        logic               gev;
        logic               gflag;
    } frame_summary_t;

    frame_summary_t summary_q[$];

    logic [23:0] gbox_lo, gbox_hi, rbox_lo, rbox_hi;
    int          gtally, rtally, vfill;
    logic        vwin[WINDOW_LEN];
    logic        seen_st, cross_st, go_st;

    assign pending_frames = summary_q.size();

    function automatic int rnd_shift(input int x);
        int y;
        begin
            y = x + (1 << (HSV_SHIFT - 1));
            if (y >= 0)
                return y >>> HSV_SHIFT;
            return -((-y + (1 << HSV_SHIFT) - 1) >>> HSV_SHIFT);
        end
    endfunction

    function automatic logic [23:0] pixel_hsv(input int b, input int g, input int r);
        int v, vmin, d, s, h, sr, hr;
        begin
            v = b;
            vmin = b;
            if (g > v) v = g;
            if (r > v) v = r;
            if (g < vmin) vmin = g;
            if (r < vmin) vmin = r;
            d = v - vmin;
            sr = (v == 0) ? 0 : (2 * (255 << HSV_SHIFT) + v) / (2 * v);
            hr = (d == 0) ? 0 : (2 * ((180 << HSV_SHIFT) / 6) + d) / (2 * d);
            s = rnd_shift(d * sr);
            if (v == r)
                h = g - b;
            else if (v == g)
                h = b - r + 2 * d;
            else
                h = r - g + 4 * d;
            h = rnd_shift(h * hr);
            if (h < 0)
                h += 180;
            return {h[7:0], s[7:0], v[7:0]};
        end
    endfunction

    function automatic bit box_hit(input logic [23:0] p, input logic [23:0] lo,
                                   input logic [23:0] hi);
        begin
            for (int k = 0; k < 24; k += 8)
                if (p[k+:8] < lo[k+:8] || p[k+:8] > hi[k+:8])
                    return 0;
            return 1;
        end
    endfunction

    task automatic predict_item();
        logic [23:0]    p;
        frame_summary_t fs;
        int             sum;
        begin
            if (kind) begin
                cross_st = crossing_request;
                return;
            end
            p = pixel_hsv(int'(blue), int'(green), int'(red));
            if (box_hit(p, gbox_lo, gbox_hi) && gtally < MAX_FRAME_PIXELS)
                gtally++;
            if (box_hit(p, rbox_lo, rbox_hi) && rtally < MAX_FRAME_PIXELS)
                rtally++;
            if (!frame_end)
                return;
            fs = '0;
            fs.gev = 0;
            fs.vote = (gtally > rtally) ? VOTE_GO : (rtally > gtally) ? VOTE_STOP : VOTE_NONE;
            if (fs.vote != VOTE_NONE && vfill < WINDOW_LEN) begin
                vwin[vfill] = (fs.vote == VOTE_GO);
                vfill++;
            end
            if (vfill >= WINDOW_LEN) begin
                sum = 0;
                for (int i = 0; i < WINDOW_LEN; i++)
                    sum += int'(vwin[i]);
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                    vwin[i] = vwin[i+1];
                vwin[WINDOW_LEN-1] = 0;
                if (2 * sum >= vfill) begin
                    if (seen_st && cross_st) begin
                        go_st = 1;
                        fs.gev = 1;
                        seen_st = 0;
                        cross_st = 0;
                        foreach (vwin[i]) vwin[i] = 0;
                        vfill = 0;
                    end else begin
                        vfill--;
                    end
                end else begin
                    seen_st = 1;
                    vfill--;
                end
            end
            fs.gcnt = gtally[TALLY_W-1:0];
            fs.rcnt = rtally[TALLY_W-1:0];
            fs.fill = vfill[FILL_W-1:0];
            fs.seen = seen_st;
            fs.gflag = go_st;
            summary_q.insert(summary_q.size(), fs);
            gtally = 0;
            rtally = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        frame_summary_t exp_fs, got;
        if (!rst_n) begin
            gbox_lo = GREEN_LOW_RST;
            gbox_hi = GREEN_HIGH_RST;
            rbox_lo = RED_LOW_RST;
            rbox_hi = RED_HIGH_RST;
            gtally = 0;
            rtally = 0;
            vfill = 0;
            foreach (vwin[i]) vwin[i] = 0;
            seen_st = 0;
            cross_st = 0;
            go_st = 0;
            fail_count = 0;
            summary_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GREEN_LOW:  gbox_lo = pwdata[23:0];
                    REG_GREEN_HIGH: gbox_hi = pwdata[23:0];
                    REG_RED_LOW:    rbox_lo = pwdata[23:0];
                    REG_RED_HIGH:   rbox_hi = pwdata[23:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                got = {frame_vote, green_pixels, red_pixels, window_fill,
                       red_seen_out, go_event, go_flag};
                if (summary_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h", got);
                end else begin
                    exp_fs = summary_q.pop_front();
                    if (got !== exp_fs) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: vote %0d/%0d g %0d/%0d r %0d/%0d ",
                                      "fill %0d/%0d seen %0b/%0b gev %0b/%0b ",
                                      "go %0b/%0b (exp/act)"},
                                     exp_fs.vote, got.vote, exp_fs.gcnt, got.gcnt,
                                     exp_fs.rcnt, got.rcnt, exp_fs.fill, got.fill,
                                     exp_fs.seen, got.seen, exp_fs.gev, got.gev,
                                     exp_fs.gflag, got.gflag);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_item();
        end
    end

endmodule

@@ dv/hsv_color_vote_go_detector_tb.sv @@
// ----------------------------------------------------------------------------
// hsv_color_vote_go_detector_tb
// Drives pixel frames and crossing requests into the go detector with random
// idling and result stalls, rewrites the color boxes between phases, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module hsv_color_vote_go_detector_tb;
    import hsvgo_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                psel, penable, pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid, in_stall;
    logic                kind;
    logic [7:0]          blue, green, red;
    logic                frame_end, crossing_request;
    logic                out_valid, out_stall;
    logic [1:0]          frame_vote;
    logic [TALLY_W-1:0]  green_pixels, red_pixels;
    logic [FILL_W-1:0]   window_fill;
    logic                red_seen_out, go_event, go_flag;
    int                  fail_count, pending_frames;
    int                  idle_pct;
    bit                  hold_off;
    int                  item_count;

    hsv_color_vote_go_detector dut (.*);

    hsv_color_vote_go_detector_chk chk (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    task automatic write_box(input logic [1:0] idx, input logic [23:0] val);
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= {8'd0, val};
            penable <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    task automatic drain_results();
        begin
            while (pending_frames != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic k, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r, input logic fe, input logic cr);
        begin
            while ($urandom_range(99) < idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            kind <= k;
            blue <= b;
            green <= g;
            red <= r;
            frame_end <= fe;
            crossing_request <= cr;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            item_count++;
        end
    endtask

    task automatic send_color_pixel(input int flavor, input logic fe);
        begin
            case (flavor)
                0: send_item(1'b0, 8'($urandom_range(60)), 8'($urandom_range(255, 180)),
                             8'($urandom_range(60)), fe, 1'b0);
                1: send_item(1'b0, 8'($urandom_range(50)), 8'($urandom_range(50)),
                             8'($urandom_range(255, 160)), fe, 1'b0);
                default: send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                                   fe, 1'b0);
            endcase
        end
    endtask

    task automatic send_frame(input int bias);
        int n;
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_color_pixel(($urandom_range(99) < 75) ? bias : 2, i == n - 1);
        end
    endtask

    initial begin
        int bias;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; kind = 0; blue = 0; green = 0; red = 0;
        frame_end = 0; crossing_request = 0;
        idle_pct = 25;
        hold_off = 0;
        item_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, grey, black, hue ties
        send_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_item(1'b0, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
        send_item(1'b0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0);
        send_item(1'b0, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0);
        send_item(1'b0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0);
        send_item(1'b0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
        send_item(1'b0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b0);
        send_item(1'b0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
        send_item(1'b0, 8'd10, 8'd200, 8'd20, 1'b1, 1'b0);
        send_item(1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        send_item(1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_item(1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        for (int i = 0; i < 11; i++)
            send_item(1'b0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
        in_valid <= 1'b0;
        drain_results();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_frame($urandom_range(1));
        join
        in_valid <= 1'b0;
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_box(REG_GREEN_LOW, 24'h000000);
                    write_box(REG_GREEN_HIGH, 24'hFFFFFF);
                    write_box(REG_RED_LOW, 24'hFFFFFF);
                    write_box(REG_RED_HIGH, 24'h000000);
                end
                1: begin
                    write_box(REG_GREEN_LOW, GREEN_LOW_RST);
                    write_box(REG_GREEN_HIGH, GREEN_HIGH_RST);
                    write_box(REG_RED_LOW, RED_LOW_RST);
                    write_box(REG_RED_HIGH, RED_HIGH_RST);
                end
                5: begin
                    write_box(REG_GREEN_LOW, 24'h000000);
                    write_box(REG_GREEN_HIGH, 24'hFFFFFF);
                    write_box(REG_RED_LOW, 24'h000000);
                    write_box(REG_RED_HIGH, 24'hFFFFFF);
                end
                default: begin
                    write_box(REG_GREEN_LOW, 24'($urandom) & 24'h3F3F7F);
                    write_box(REG_GREEN_HIGH, 24'($urandom) | 24'h80C0C0);
                    write_box(REG_RED_LOW, 24'($urandom) & 24'h1F3F7F);
                    write_box(REG_RED_HIGH, 24'($urandom) | 24'h40C0C0);
                end
            endcase
            idle_pct = (phase == 3) ? 0 : 25;
            while (item_count < 60 + (phase + 1) * 180) begin
                bias = ($urandom_range(99) < 50) ? 1 : 0;
                for (int f = 0; f < 12; f++)
                    send_frame(bias);
                if ($urandom_range(99) < 60)
                    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom), $urandom_range(99) < 80);
            end
            in_valid <= 1'b0;
            drain_results();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
